// ===== rtl/core/bitmap_row_run_rectangles_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap row run rectangle block
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BITMAP_ROW_RUN_RECTANGLES_TOP_ASSERT_SVH
`define BITMAP_ROW_RUN_RECTANGLES_TOP_ASSERT_SVH

// same-cycle implication
`define BRR_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define BRR_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/brr_pkg.sv =====
// ----------------------------------------------------------------------------
// brr_pkg
// Shared types, constants and helpers of the bitmap row run rectangle block.
// ----------------------------------------------------------------------------
package brr_pkg;

    localparam int ROW_BITS_DEFAULT = 32;
    localparam int RUN_LIMIT        = 16;
    localparam int RUN_CNT_W        = $clog2(RUN_LIMIT);
    localparam int QUEUE_DEPTH      = 2;
    localparam int EDGE_W           = 20;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_LEFT      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_TOP       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_RIGHT     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_BOTTOM    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SURFACE_WIDTH  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SURFACE_HEIGHT = 3'd5;

    localparam logic signed [15:0] CLIP_LEFT_RESET   = 16'sd0;
    localparam logic signed [15:0] CLIP_TOP_RESET    = 16'sd0;
    localparam logic signed [15:0] CLIP_RIGHT_RESET  = 16'sd16384;
    localparam logic signed [15:0] CLIP_BOTTOM_RESET = 16'sd16384;
    localparam logic [14:0]        SURFACE_RESET     = 15'd16384;

    typedef logic signed [EDGE_W-1:0] edge_t;

    typedef struct packed {
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_top;
        logic signed [15:0] clip_right;
        logic signed [15:0] clip_bottom;
        logic [14:0]        surface_width;
        logic [14:0]        surface_height;
    } brr_cfg_t;

    // one row after classification, y extent already clipped
    typedef struct packed {
        logic signed [15:0] origin_x;
        logic [4:0]         scale;
        logic signed [15:0] rect_y;
        logic signed [16:0] rect_height;
        logic [31:0]        colour;
    } brr_desc_t;

    function automatic edge_t edge_max(edge_t a, edge_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic edge_t edge_min(edge_t a, edge_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [15:0] sat_edge(edge_t v);
        logic signed [15:0] r;
        if (v > edge_t'(32767))
            r = 16'sh7FFF;
        else if (v < edge_t'(-32768))
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [16:0] sat_span(edge_t v);
        logic signed [16:0] r;
        if (v > edge_t'(65535))
            r = 17'sh0FFFF;
        else if (v < edge_t'(-65536))
            r = 17'sh10000;
        else
            r = v[16:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/brr_front.sv =====
// ----------------------------------------------------------------------------
// brr_front
// Accepts rows, masks unused columns, clips the y extent and drops empty rows.
// ----------------------------------------------------------------------------
module brr_front #(
    parameter int ROW_BITS = brr_pkg::ROW_BITS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [ROW_BITS-1:0]     row_bits,
    input  logic [5:0]              bit_count,
    input  logic [9:0]              row_index,
    input  logic signed [15:0]      origin_x,
    input  logic signed [15:0]      origin_y,
    input  logic [4:0]              scale,
    input  logic [31:0]             colour,
    input  brr_pkg::brr_cfg_t       cfg,
    output logic                    push,
    input  logic                    queue_full,
    output brr_pkg::brr_desc_t      push_desc,
    output logic [ROW_BITS-1:0]     push_row
);
    import brr_pkg::*;

    localparam int CNT_W = $clog2(ROW_BITS + 1);

    logic                   f_valid_reg;
    logic [ROW_BITS-1:0]    f_row_reg;
    logic [14:0]            f_prod_reg;
    logic signed [15:0]     f_ox_reg;
    logic signed [15:0]     f_oy_reg;
    logic [4:0]             f_scale_reg;
    logic [31:0]            f_colour_reg;

    logic [CNT_W-1:0]       cols;
    logic [ROW_BITS-1:0]    col_mask;
    logic                   accept;
    logic                   nonempty;
    logic                   f_done;
    edge_t                  y_top;
    edge_t                  y_bot;
    edge_t                  y1;
    edge_t                  y2;

    // clamp the column count to the row width
    always_comb
    begin
        if ({1'b0, bit_count} > 7'(ROW_BITS))
            cols = CNT_W'(ROW_BITS);
        else
            cols = CNT_W'(bit_count);
        col_mask = ~({ROW_BITS{1'b1}} >> cols);
    end

    assign accept   = in_valid && in_ready;
    assign nonempty = |f_row_reg;
    assign push     = f_valid_reg && nonempty && !queue_full;
    assign f_done   = f_valid_reg && (!nonempty || !queue_full);
    assign in_ready = !f_valid_reg || f_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (accept)
            f_valid_reg <= 1'b1;
        else if (f_done)
            f_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_row_reg    <= row_bits & col_mask;
            f_prod_reg   <= 15'(row_index) * 15'(scale);
            f_ox_reg     <= origin_x;
            f_oy_reg     <= origin_y;
            f_scale_reg  <= scale;
            f_colour_reg <= colour;
        end
    end

    always_comb
    begin
        y_top = edge_t'(f_oy_reg) + edge_t'($signed({1'b0, f_prod_reg}));
        y_bot = y_top + edge_t'($signed({1'b0, f_scale_reg}));
        y1    = edge_max(edge_max(y_top, edge_t'(cfg.clip_top)), '0);
        y2    = edge_min(edge_min(y_bot, edge_t'(cfg.clip_bottom)),
                         edge_t'($signed({1'b0, cfg.surface_height})));
        push_desc.origin_x    = f_ox_reg;
        push_desc.scale       = f_scale_reg;
        push_desc.rect_y      = sat_edge(y1);
        push_desc.rect_height = sat_span(y2 - y1);
        push_desc.colour      = f_colour_reg;
        push_row              = f_row_reg;
    end

endmodule

// ===== rtl/core/brr_queue.sv =====
// ----------------------------------------------------------------------------
// brr_queue
// Short FIFO of classified rows between the front and the run walker.
// ----------------------------------------------------------------------------
module brr_queue #(
    parameter int ROW_BITS = brr_pkg::ROW_BITS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  brr_pkg::brr_desc_t      push_desc,
    input  logic [ROW_BITS-1:0]     push_row,
    output logic                    full,
    input  logic                    pop,
    output logic                    head_valid,
    output brr_pkg::brr_desc_t      head_desc,
    output logic [ROW_BITS-1:0]     head_row
);
    import brr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    brr_desc_t              desc_q [QUEUE_DEPTH];
    logic [ROW_BITS-1:0]    row_q  [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = desc_q[rd_ptr_reg];
    assign head_row   = row_q[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            desc_q[wr_ptr_reg] <= push_desc;
            row_q[wr_ptr_reg]  <= push_row;
        end
    end

endmodule

// ===== rtl/core/brr_back.sv =====
// ----------------------------------------------------------------------------
// brr_back
// Walks up to RUN_LIMIT runs of a row, one run a cycle unless the output stalls; scales, clips and emits them.
// ----------------------------------------------------------------------------
`include "bitmap_row_run_rectangles_top_assert.svh"

module brr_back #(
    parameter int ROW_BITS = brr_pkg::ROW_BITS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  brr_pkg::brr_cfg_t       cfg,
    input  logic                    q_valid,
    input  brr_pkg::brr_desc_t      q_desc,
    input  logic [ROW_BITS-1:0]     q_row,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [15:0]      rect_x,
    output logic signed [15:0]      rect_y,
    output logic signed [16:0]      rect_width,
    output logic signed [16:0]      rect_height,
    output logic [31:0]             paint_colour,
    output logic                    last_run
);
    import brr_pkg::*;

    localparam int CNT_W  = $clog2(ROW_BITS + 1);
    localparam int PROD_W = CNT_W + 5;

    // run walker
    logic                   r_valid_reg;
    logic [ROW_BITS-1:0]    w_reg;
    logic [ROW_BITS-1:0]    w_next;
    brr_desc_t              d_reg;
    logic [RUN_CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]       run_col;
    logic [CNT_W-1:0]       run_end;
    logic [ROW_BITS:0]      ends;
    logic                   r_last;
    logic                   r_free;
    logic                   adv;

    // scale stage
    logic                   m_valid_reg;
    logic                   m_last_reg;
    logic [PROD_W-1:0]      m_col_prod_reg;
    logic [PROD_W-1:0]      m_end_prod_reg;
    brr_desc_t              m_desc_reg;

    // clip stage and output register
    edge_t                  x_left;
    edge_t                  x_right;
    edge_t                  x1;
    edge_t                  x2;
    logic                   out_valid_reg;
    logic signed [15:0]     rect_x_reg;
    logic signed [15:0]     rect_y_reg;
    logic signed [16:0]     rect_width_reg;
    logic signed [16:0]     rect_height_reg;
    logic [31:0]            paint_colour_reg;
    logic                   last_run_reg;

    // column of the highest set bit; bit ROW_BITS is column zero
    function automatic logic [CNT_W-1:0] first_one(logic [ROW_BITS:0] v);
        logic [CNT_W-1:0] pos;
        pos = CNT_W'(ROW_BITS);
        for (int i = 0; i <= ROW_BITS; i++)
        begin
            if (v[i])
                pos = CNT_W'(ROW_BITS - i);
        end
        return pos;
    endfunction

    always_comb
    begin
        // a run ends at a column that is clear with its left neighbor set
        ends    = ({w_reg, 1'b0} >> 1) & ~{w_reg, 1'b0};
        run_col = first_one({w_reg, 1'b1});
        run_end = first_one(ends);
        w_next  = w_reg & ({ROW_BITS{1'b1}} >> run_end);
        r_last  = (w_next == '0) || (n_reg == RUN_CNT_W'(RUN_LIMIT - 1));
    end

    assign adv    = !out_valid_reg || out_ready;
    assign r_free = !r_valid_reg || (adv && r_last);
    assign pop    = q_valid && r_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                r_valid_reg <= 1'b1;
            else if (adv && r_last)
                r_valid_reg <= 1'b0;
            if (adv)
            begin
                m_valid_reg   <= r_valid_reg;
                out_valid_reg <= m_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            w_reg <= q_row;
            d_reg <= q_desc;
            n_reg <= '0;
        end
        else if (adv && r_valid_reg)
        begin
            w_reg <= w_next;
            n_reg <= n_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_last_reg     <= r_last;
            m_col_prod_reg <= PROD_W'(run_col) * PROD_W'(d_reg.scale);
            m_end_prod_reg <= PROD_W'(run_end) * PROD_W'(d_reg.scale);
            m_desc_reg     <= d_reg;
        end
    end

    always_comb
    begin
        x_left  = edge_t'(m_desc_reg.origin_x) + edge_t'($signed({1'b0, m_col_prod_reg}));
        x_right = edge_t'(m_desc_reg.origin_x) + edge_t'($signed({1'b0, m_end_prod_reg}));
        x1      = edge_max(edge_max(x_left, edge_t'(cfg.clip_left)), '0);
        x2      = edge_min(edge_min(x_right, edge_t'(cfg.clip_right)),
                           edge_t'($signed({1'b0, cfg.surface_width})));
    end

    always_ff @(posedge clk)
    begin
        if (adv && m_valid_reg)
        begin
            rect_x_reg       <= sat_edge(x1);
            rect_y_reg       <= m_desc_reg.rect_y;
            rect_width_reg   <= sat_span(x2 - x1);
            rect_height_reg  <= m_desc_reg.rect_height;
            paint_colour_reg <= m_desc_reg.colour;
            last_run_reg     <= m_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rect_x       = rect_x_reg;
    assign rect_y       = rect_y_reg;
    assign rect_width   = rect_width_reg;
    assign rect_height  = rect_height_reg;
    assign paint_colour = paint_colour_reg;
    assign last_run     = last_run_reg;

    `BRR_ASSERT_IMPL(a_row_has_run, r_valid_reg, w_reg != '0, "walker holds a row without runs")
    `BRR_ASSERT_IMPL(a_pop_nonempty, pop, q_valid, "row taken from an empty queue")
    `BRR_ASSERT_IMPL(a_row_kept, m_valid_reg && !m_last_reg, r_valid_reg, "row dropped before its last run")
    `BRR_ASSERT_NEXT(a_stall_holds, out_valid_reg && !out_ready, $stable(m_valid_reg) && $stable(m_last_reg), "scale stage moved during output stall")

endmodule

// ===== rtl/core/bitmap_row_run_rectangles_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_row_run_rectangles_top
// Turns monochrome bitmap rows into clipped run rectangles, one per run, up to RUN_LIMIT runs a row.
// ----------------------------------------------------------------------------
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid/in_ready, row_bits .. colour         | sink
//  out     | out_valid/out_ready, rect_x .. last_run       | source
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data      | sink
//
//  The run walker emits one rectangle per cycle unless the output stalls, so a
//  row holds the back end until its last run is walked; a row with no set bits
//  is dropped in the front. Before its first result reaches the output, a row
//  passes the front register, the queue, the walker, the scale and output stages.
//  A two-row queue lets the front take rows while the walker is busy.
//  Reset returns the clip window and surface size to their defaults.
//  cfg_ready is always high; write registers only when no row is in flight.
// ----------------------------------------------------------------------------
module bitmap_row_run_rectangles_top #(
    parameter int ROW_BITS = brr_pkg::ROW_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ROW_BITS-1:0]                 row_bits,
    input  logic [5:0]                          bit_count,
    input  logic [9:0]                          row_index,
    input  logic signed [15:0]                  origin_x,
    input  logic signed [15:0]                  origin_y,
    input  logic [4:0]                          scale,
    input  logic [31:0]                         colour,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [15:0]                  rect_x,
    output logic signed [15:0]                  rect_y,
    output logic signed [16:0]                  rect_width,
    output logic signed [16:0]                  rect_height,
    output logic [31:0]                         paint_colour,
    output logic                                last_run,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [brr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [brr_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import brr_pkg::*;

    brr_cfg_t               cfg_reg;
    brr_cfg_t               cfg_next;
    logic                   push;
    logic                   queue_full;
    brr_desc_t              push_desc;
    logic [ROW_BITS-1:0]    push_row;
    logic                   pop;
    logic                   head_valid;
    brr_desc_t              head_desc;
    logic [ROW_BITS-1:0]    head_row;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CLIP_LEFT:      cfg_next.clip_left      = $signed(cfg_data);
                CFG_CLIP_TOP:       cfg_next.clip_top       = $signed(cfg_data);
                CFG_CLIP_RIGHT:     cfg_next.clip_right     = $signed(cfg_data);
                CFG_CLIP_BOTTOM:    cfg_next.clip_bottom    = $signed(cfg_data);
                CFG_SURFACE_WIDTH:  cfg_next.surface_width  = cfg_data[14:0];
                CFG_SURFACE_HEIGHT: cfg_next.surface_height = cfg_data[14:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clip_left      <= CLIP_LEFT_RESET;
            cfg_reg.clip_top       <= CLIP_TOP_RESET;
            cfg_reg.clip_right     <= CLIP_RIGHT_RESET;
            cfg_reg.clip_bottom    <= CLIP_BOTTOM_RESET;
            cfg_reg.surface_width  <= SURFACE_RESET;
            cfg_reg.surface_height <= SURFACE_RESET;
        end
        else
            cfg_reg <= cfg_next;
    end

    brr_front #(
        .ROW_BITS (ROW_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .row_bits   (row_bits),
        .bit_count  (bit_count),
        .row_index  (row_index),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .scale      (scale),
        .colour     (colour),
        .cfg        (cfg_reg),
        .push       (push),
        .queue_full (queue_full),
        .push_desc  (push_desc),
        .push_row   (push_row)
    );

    brr_queue #(
        .ROW_BITS (ROW_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .push_row   (push_row),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .head_row   (head_row)
    );

    brr_back #(
        .ROW_BITS (ROW_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (head_valid),
        .q_desc       (head_desc),
        .q_row        (head_row),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rect_x       (rect_x),
        .rect_y       (rect_y),
        .rect_width   (rect_width),
        .rect_height  (rect_height),
        .paint_colour (paint_colour),
        .last_run     (last_run)
    );

endmodule
